[hdl/assert_macros.svh]
// Assertion macros shared by the RTL of the slot binder.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[hdl/fmsb_pkg.sv]
// Package of the slot binder: sizes, status codes and small helper functions.
// Depends on nothing; imported by fir_mac_slot_binder_unit.
package fmsb_pkg;

   localparam int MAX_SLOTS   = 64;
   localparam int MAX_UNITS   = 8;
   localparam int MAX_FILTERS = 15;

   localparam int SLOT_W  = 6;
   localparam int UNIT_W  = 3;
   localparam int ADDR_W  = UNIT_W + SLOT_W;
   localparam int NSL_W   = 7;
   localparam int LAT_W   = 6;
   localparam int ID_W    = 8;
   localparam int CNT_W   = 7;
   localparam int RATIO_W = 16;
   localparam int STAT_W  = 2;
   localparam int FCNT_W  = 4;
   localparam int UIU_W   = 4;
   localparam int UPD_W   = 1 + ID_W;
   localparam int COEF_W  = 1 + ID_W + SLOT_W;

   localparam logic [STAT_W-1:0] STAT_PLACED    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_RATE_HIGH = 2'd1;
   localparam logic [STAT_W-1:0] STAT_COEFF     = 2'd2;
   localparam logic [STAT_W-1:0] STAT_NO_UNIT   = 2'd3;

   localparam logic [0:0] REG_NUM_SLOTS      = 1'b0;
   localparam logic [0:0] REG_UPDATE_LATENCY = 1'b1;

   // Slot count as used: zero counts as one, anything above the maximum is clamped.
   function automatic logic [NSL_W-1:0] eff_slots(input logic [NSL_W-1:0] ns);
      logic [NSL_W-1:0] r;
      r = ns;
      if (ns == '0) begin
         r = NSL_W'(1);
      end else if (ns > NSL_W'(MAX_SLOTS)) begin
         r = NSL_W'(MAX_SLOTS);
      end
      return r;
   endfunction

   // Smallest power of two not below the count (count never exceeds 64 here).
   function automatic logic [CNT_W-1:0] fifo_size(input logic [CNT_W-1:0] cnt);
      logic [CNT_W-1:0] w;
      w = CNT_W'(1);
      for (int k = 0; k < CNT_W - 1; k++) begin
         if (w < cnt) begin
            w = w << 1;
         end
      end
      return w;
   endfunction

endpackage

[hdl/fir_mac_slot_binder_unit.sv]
// Top level of the slot binder: sequencer, slot tables in two memories, result register.
// Depends on fmsb_pkg and assert_macros.svh.
`include "assert_macros.svh"

// Places one filter per request word on a pool of eight time-slotted multiply-accumulate
// units and answers with one result word: status, unit, origin, interval and FIFO size.
// After reset the block first clears all 512 entries of both slot tables, one a cycle,
// and takes no request word until that pass is done; configuration writes are taken at any
// time but must only be made while the block is idle. A request is then worked on alone:
// the latency is reduced modulo n and the interval found by a subtract loop, then a search
// runs over candidate units and origins up to the first unit not yet in use, skipping full
// units and stopping at the first fit, in which each table entry needed is read and checked
// through the single port of its memory; on a fit the entries of the filter are marked,
// one entry a cycle. The memory port therefore sets the rate at which requests are served.
// A finished result sits in the output register, so the next request word may be
// accepted while the previous result still waits to be taken.
module fir_mac_slot_binder_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [fmsb_pkg::ID_W-1:0]        req_filter_id,
   input  logic [fmsb_pkg::CNT_W-1:0]       req_coeff_count,
   input  logic [fmsb_pkg::RATIO_W-1:0]     req_clocks_per_sample,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [fmsb_pkg::STAT_W-1:0]      rsp_status,
   output logic [fmsb_pkg::UNIT_W-1:0]      rsp_unit_index,
   output logic [fmsb_pkg::SLOT_W-1:0]      rsp_slot_origin,
   output logic [fmsb_pkg::NSL_W-1:0]       rsp_slot_interval,
   output logic [fmsb_pkg::CNT_W-1:0]       rsp_fifo_words,
   input  logic                             csr_wr_en,
   input  logic [0:0]                       csr_index,
   input  logic [fmsb_pkg::NSL_W-1:0]       csr_wr_data
);
   import fmsb_pkg::*;

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_LAT, S_DIV, S_CAND, S_URD, S_UCK, S_CRD, S_CCK,
      S_NEXT, S_MARKU, S_MARKC, S_FIN, S_DONE
   } state_type;

   state_type            state_ff;
   logic [ADDR_W-1:0]    clr_ff;
   logic [NSL_W-1:0]     num_slots_ff;
   logic [LAT_W-1:0]     update_latency_ff;

   logic [ID_W-1:0]      id_ff;
   logic [CNT_W-1:0]     count_ff;
   logic [NSL_W-1:0]     n_ff;
   logic [NSL_W-1:0]     lat_ff;
   logic [NSL_W-1:0]     div_ff;
   logic [NSL_W-1:0]     rem_ff;
   logic [NSL_W-1:0]     interval_ff;
   logic [UNIT_W-1:0]    unit_ff;
   logic [UNIT_W-1:0]    last_ff;
   logic [SLOT_W-1:0]    origin_ff;
   logic [NSL_W-1:0]     t_ff;
   logic [SLOT_W-1:0]    i_ff;
   logic                 sub_ff;
   logic [STAT_W-1:0]    res_status_ff;

   logic [FCNT_W-1:0]    fcnt_ff [MAX_UNITS];
   logic [UIU_W-1:0]     units_in_use_ff;

   logic                 rsp_valid_ff;
   logic [STAT_W-1:0]    rsp_status_ff;
   logic [UNIT_W-1:0]    rsp_unit_ff;
   logic [SLOT_W-1:0]    rsp_origin_ff;
   logic [NSL_W-1:0]     rsp_interval_ff;
   logic [CNT_W-1:0]     rsp_words_ff;

   logic [UPD_W-1:0]     upd_mem [MAX_UNITS*MAX_SLOTS];
   logic [COEF_W-1:0]    coef_mem [MAX_UNITS*MAX_SLOTS];
   logic [UPD_W-1:0]     upd_rd_ff;
   logic [COEF_W-1:0]    coef_rd_ff;

   logic                 req_acc;
   logic [NSL_W-1:0]     n_req;
   logic [NSL_W-1:0]     t_next;
   logic [NSL_W-1:0]     lat_slot;
   logic [NSL_W-1:0]     coef_slot;
   logic [ADDR_W-1:0]    upd_addr;
   logic [ADDR_W-1:0]    coef_addr;
   logic                 upd_we;
   logic                 coef_we;
   logic [UPD_W-1:0]     upd_wdata;
   logic [COEF_W-1:0]    coef_wdata;
   logic [CNT_W-1:0]     i_next;
   logic [SLOT_W-1:0]    coef_index;

   assign req_ready = (state_ff == S_IDLE);
   assign req_acc   = req_valid && req_ready;
   assign n_req     = eff_slots(num_slots_ff);
   assign t_next    = t_ff + interval_ff;
   assign i_next    = CNT_W'(i_ff) + CNT_W'(1);

   // Slot one latency before the update slot, and slot of coefficient i, both modulo n.
   assign lat_slot  = (t_ff >= lat_ff) ? (t_ff - lat_ff) : (t_ff + n_ff - lat_ff);
   assign coef_slot = (t_ff >= NSL_W'(i_ff)) ? (t_ff - NSL_W'(i_ff))
                                             : (t_ff + n_ff - NSL_W'(i_ff));
   assign coef_index = SLOT_W'(count_ff - CNT_W'(1) - CNT_W'(i_ff));

   always_comb begin
      upd_addr   = {unit_ff, (sub_ff ? lat_slot[SLOT_W-1:0] : t_ff[SLOT_W-1:0])};
      coef_addr  = {unit_ff, coef_slot[SLOT_W-1:0]};
      upd_we     = 1'b0;
      coef_we    = 1'b0;
      upd_wdata  = {1'b1, id_ff};
      coef_wdata = {1'b1, id_ff, coef_index};
      case (state_ff)
         S_CLEAR: begin
            upd_addr   = clr_ff;
            coef_addr  = clr_ff;
            upd_we     = 1'b1;
            coef_we    = 1'b1;
            upd_wdata  = '0;
            coef_wdata = '0;
         end
         S_MARKU: begin
            upd_addr = {unit_ff, t_ff[SLOT_W-1:0]};
            upd_we   = 1'b1;
         end
         S_MARKC: begin
            coef_we = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (upd_we) begin
         upd_mem[upd_addr] <= upd_wdata;
      end
      upd_rd_ff <= upd_mem[upd_addr];
   end

   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_addr] <= coef_wdata;
      end
      coef_rd_ff <= coef_mem[coef_addr];
   end

   // Sequencer, configuration registers and result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff          <= S_CLEAR;
         clr_ff            <= '0;
         num_slots_ff      <= NSL_W'(MAX_SLOTS);
         update_latency_ff <= LAT_W'(1);
         units_in_use_ff   <= '0;
         rsp_valid_ff      <= 1'b0;
         for (int u = 0; u < MAX_UNITS; u++) begin
            fcnt_ff[u] <= '0;
         end
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               REG_NUM_SLOTS:      num_slots_ff      <= csr_wr_data;
               REG_UPDATE_LATENCY: update_latency_ff <= csr_wr_data[LAT_W-1:0];
               default: begin
               end
            endcase
         end
         // A taken result empties the register unless a new one is loaded in this cycle.
         if (rsp_valid_ff && rsp_ready && state_ff != S_DONE) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + ADDR_W'(1);
               if (&clr_ff) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (req_acc) begin
                  id_ff    <= req_filter_id;
                  count_ff <= req_coeff_count;
                  n_ff     <= n_req;
                  lat_ff   <= NSL_W'(update_latency_ff);
                  rem_ff   <= n_req;
                  if (req_clocks_per_sample > RATIO_W'(NSL_W'(n_req))) begin
                     div_ff <= n_req;
                  end else begin
                     div_ff <= req_clocks_per_sample[NSL_W-1:0];
                  end
                  if (req_clocks_per_sample < RATIO_W'(2)) begin
                     res_status_ff <= STAT_RATE_HIGH;
                     state_ff      <= S_DONE;
                  end else begin
                     state_ff <= S_LAT;
                  end
               end
            end
            S_LAT: begin
               if (lat_ff >= n_ff) begin
                  lat_ff <= lat_ff - n_ff;
               end else begin
                  state_ff <= S_DIV;
               end
            end
            S_DIV: begin
               // Largest divisor of n not above the clamped ratio, by repeated subtraction.
               if (div_ff == NSL_W'(1) || rem_ff == '0) begin
                  interval_ff <= div_ff;
                  unit_ff     <= '0;
                  origin_ff   <= '0;
                  last_ff     <= (units_in_use_ff >= UIU_W'(MAX_UNITS))
                                 ? UNIT_W'(MAX_UNITS - 1) : units_in_use_ff[UNIT_W-1:0];
                  if (count_ff > div_ff) begin
                     res_status_ff <= STAT_COEFF;
                     state_ff      <= S_DONE;
                  end else begin
                     state_ff <= S_CAND;
                  end
               end else if (rem_ff >= div_ff) begin
                  rem_ff <= rem_ff - div_ff;
               end else begin
                  div_ff <= div_ff - NSL_W'(1);
                  rem_ff <= n_ff;
               end
            end
            S_CAND: begin
               t_ff   <= NSL_W'(origin_ff);
               sub_ff <= 1'b0;
               i_ff   <= '0;
               if (fcnt_ff[unit_ff] >= FCNT_W'(MAX_FILTERS)) begin
                  state_ff <= S_NEXT;
               end else begin
                  state_ff <= S_URD;
               end
            end
            S_URD: begin
               state_ff <= S_UCK;
            end
            S_UCK: begin
               if (upd_rd_ff[UPD_W-1]) begin
                  state_ff <= S_NEXT;
               end else if (!sub_ff) begin
                  sub_ff   <= 1'b1;
                  state_ff <= S_URD;
               end else begin
                  sub_ff <= 1'b0;
                  if (t_next >= n_ff) begin
                     t_ff <= NSL_W'(origin_ff);
                     if (count_ff == '0) begin
                        state_ff <= S_MARKU;
                     end else begin
                        state_ff <= S_CRD;
                     end
                  end else begin
                     t_ff     <= t_next;
                     state_ff <= S_URD;
                  end
               end
            end
            S_CRD: begin
               state_ff <= S_CCK;
            end
            S_CCK: begin
               if (coef_rd_ff[COEF_W-1]) begin
                  state_ff <= S_NEXT;
               end else if (i_next < count_ff) begin
                  i_ff     <= i_ff + SLOT_W'(1);
                  state_ff <= S_CRD;
               end else begin
                  i_ff <= '0;
                  if (t_next >= n_ff) begin
                     t_ff     <= NSL_W'(origin_ff);
                     state_ff <= S_MARKU;
                  end else begin
                     t_ff     <= t_next;
                     state_ff <= S_CRD;
                  end
               end
            end
            S_NEXT: begin
               if (NSL_W'(origin_ff) + NSL_W'(1) < interval_ff) begin
                  origin_ff <= origin_ff + SLOT_W'(1);
                  state_ff  <= S_CAND;
               end else if (unit_ff != last_ff) begin
                  origin_ff <= '0;
                  unit_ff   <= unit_ff + UNIT_W'(1);
                  state_ff  <= S_CAND;
               end else begin
                  res_status_ff <= STAT_NO_UNIT;
                  state_ff      <= S_DONE;
               end
            end
            S_MARKU: begin
               if (t_next >= n_ff) begin
                  t_ff <= NSL_W'(origin_ff);
                  i_ff <= '0;
                  if (count_ff == '0) begin
                     state_ff <= S_FIN;
                  end else begin
                     state_ff <= S_MARKC;
                  end
               end else begin
                  t_ff <= t_next;
               end
            end
            S_MARKC: begin
               if (i_next < count_ff) begin
                  i_ff <= i_ff + SLOT_W'(1);
               end else begin
                  i_ff <= '0;
                  if (t_next >= n_ff) begin
                     state_ff <= S_FIN;
                  end else begin
                     t_ff <= t_next;
                  end
               end
            end
            S_FIN: begin
               fcnt_ff[unit_ff] <= fcnt_ff[unit_ff] + FCNT_W'(1);
               if (UIU_W'(unit_ff) >= units_in_use_ff) begin
                  units_in_use_ff <= UIU_W'(unit_ff) + UIU_W'(1);
               end
               res_status_ff <= STAT_PLACED;
               state_ff      <= S_DONE;
            end
            S_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= res_status_ff;
                  if (res_status_ff == STAT_PLACED) begin
                     rsp_unit_ff     <= unit_ff;
                     rsp_origin_ff   <= origin_ff;
                     rsp_interval_ff <= interval_ff;
                     rsp_words_ff    <= fifo_size(count_ff);
                  end else begin
                     rsp_unit_ff     <= '0;
                     rsp_origin_ff   <= '0;
                     rsp_interval_ff <= '0;
                     rsp_words_ff    <= '0;
                  end
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_unit_index    = rsp_unit_ff;
   assign rsp_slot_origin   = rsp_origin_ff;
   assign rsp_slot_interval = rsp_interval_ff;
   assign rsp_fifo_words    = rsp_words_ff;

   // A placed filter always starts within its first interval.
   `ASSERT_SAME(a_origin_in_interval, clock, reset, rsp_valid && rsp_status == STAT_PLACED, rsp_slot_origin < rsp_slot_interval[SLOT_W-1:0] || rsp_slot_interval == NSL_W'(MAX_SLOTS), "placed origin lies outside the interval")
   // Only one request word is worked on at a time.
   `ASSERT_NEXT(a_one_at_a_time, clock, reset, req_valid && req_ready, !req_ready, "second request word taken while one is in progress")
   // A unit that is full is never chosen.
   `ASSERT_SAME(a_unit_not_full, clock, reset, state_ff == S_FIN, fcnt_ff[unit_ff] < FCNT_W'(MAX_FILTERS), "filter placed on a full unit")

endmodule
